[sv/mptt_pkg.sv]
package mptt_pkg;

  localparam int unsigned ChannelsDefault   = 8;
  localparam int unsigned PrioLevelsDefault = 8;

  localparam int unsigned PeriodW = 32;
  localparam int unsigned PrioW   = 3;
  localparam int unsigned ChanW   = 3;

  localparam logic KIND_ADD    = 1'b0;
  localparam logic KIND_EXPIRE = 1'b1;

  localparam logic [1:0] ST_ADDED  = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_FIRED  = 2'd2;
  localparam logic [1:0] ST_REPORT = 2'd3;

  typedef struct packed {
    logic               kind;
    logic [PeriodW-1:0] period;
    logic [PrioW-1:0]   priority_req;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ChanW-1:0]   channel;
    logic [PeriodW-1:0] next_interval;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic               expire;
    logic               min_run;
    logic               take;
    logic [PrioW-1:0]   prio;
    logic [PeriodW-1:0] interval;
  } cell_ctrl_t;

endpackage

[sv/mptt_cell.sv]
module mptt_cell import mptt_pkg::*; #(
  parameter int unsigned IdxW = 3,
  parameter logic [IdxW-1:0] Index = '0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cell_ctrl_t         ctrl_i,
  input  logic               en_i,
  input  logic               wr_i,
  input  logic [PeriodW-1:0] period_i,
  input  logic [PrioW-1:0]   prio_i,
  input  logic [PeriodW-1:0] min_i,
  output logic [PeriodW-1:0] min_o,
  input  logic               found_i,
  output logic               found_o,
  input  logic [IdxW-1:0]    idx_i,
  output logic [IdxW-1:0]    idx_o
);

  logic [PeriodW-1:0] period_q;
  logic [PrioW-1:0]   prio_q;
  logic [PeriodW-1:0] counter_q;
  logic [PeriodW-1:0] min_q;
  logic               fired_q;
  logic               hit;

  assign hit     = en_i && fired_q && (prio_q == ctrl_i.prio);
  assign found_o = found_i || hit;
  assign idx_o   = found_i ? idx_i : Index;
  assign min_o   = min_q;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      period_q  <= period_i;
      prio_q    <= prio_i;
      counter_q <= period_i;
    end else if (ctrl_i.expire && en_i) begin
      if (counter_q <= ctrl_i.interval) begin
        counter_q <= period_q;
      end else begin
        counter_q <= counter_q - ctrl_i.interval;
      end
    end
    if (ctrl_i.min_run) begin
      min_q <= (en_i && (counter_q < min_i)) ? counter_q : min_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fired_q <= 1'b0;
    end else if (ctrl_i.expire) begin
      fired_q <= en_i && (counter_q <= ctrl_i.interval);
    end else if (ctrl_i.take && hit && !found_i) begin
      fired_q <= 1'b0;
    end
  end

endmodule

[sv/multi_periodic_task_timer.sv]
// An add item gives its single result, registered, in the cycle after it is accepted.
// An expiry item steps the counters; S_MIN then walks the minimum along the cell row,
// S_EMIT walks the priority levels (up to eight) giving one result per fired channel, and S_REPORT closes it.
// The block takes one item at a time and accepts the next once it is back idle and its output is not stalled.
// Reset clears the channel count, the armed interval, fired flags and output valid;
// channel entries are not cleared and no clearing pass is needed.
module multi_periodic_task_timer import mptt_pkg::*; #(
  parameter int unsigned CHANNELS        = ChannelsDefault,
  parameter int unsigned PRIORITY_LEVELS = PrioLevelsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned IdxW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CntW    = $clog2(CHANNELS + 1);
  localparam int unsigned PrioTop = ((PRIORITY_LEVELS > 8) ? 8 : PRIORITY_LEVELS) - 1;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_MIN    = 4'b0010,
    S_EMIT   = 4'b0100,
    S_REPORT = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [CntW-1:0]    step_q, step_d;
  logic [PeriodW-1:0] armed_q, armed_d;
  logic [PrioW-1:0]   pwalk_q, pwalk_d;
  logic               out_valid_q;
  out_item_t          out_q, out_d;
  logic               out_load;
  logic               can_emit;
  logic               in_acc;
  logic               add_wr;
  logic [PrioW-1:0]   prio_sat;
  cell_ctrl_t         ctrl;

  logic [PeriodW-1:0] min_chain   [CHANNELS+1];
  logic               found_chain [CHANNELS+1];
  logic [IdxW-1:0]    idx_chain   [CHANNELS+1];
  logic [CHANNELS-1:0] cell_en;
  logic [CHANNELS-1:0] cell_wr;

  assign can_emit    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign prio_sat    = (int'(in_item_i.priority_req) > PrioTop) ? PrioW'(PrioTop)
                                                               : in_item_i.priority_req;

  assign min_chain[0]   = '1;
  assign found_chain[0] = 1'b0;
  assign idx_chain[0]   = '0;

  for (genvar g = 0; g < CHANNELS; g++) begin : g_cell
    assign cell_en[g] = (count_q > CntW'(g));
    assign cell_wr[g] = add_wr && (count_q == CntW'(g));

    mptt_cell #(
      .IdxW  (IdxW),
      .Index (IdxW'(g))
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .en_i     (cell_en[g]),
      .wr_i     (cell_wr[g]),
      .period_i (in_item_i.period),
      .prio_i   (prio_sat),
      .min_i    (min_chain[g]),
      .min_o    (min_chain[g+1]),
      .found_i  (found_chain[g]),
      .found_o  (found_chain[g+1]),
      .idx_i    (idx_chain[g]),
      .idx_o    (idx_chain[g+1])
    );
  end

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    step_d        = step_q;
    armed_d       = armed_q;
    pwalk_d       = pwalk_q;
    add_wr        = 1'b0;
    out_load      = 1'b0;
    out_d         = out_q;
    ctrl.expire   = 1'b0;
    ctrl.min_run  = 1'b0;
    ctrl.take     = 1'b0;
    ctrl.prio     = pwalk_q;
    ctrl.interval = armed_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_item_i.kind == KIND_ADD) begin
            out_load           = 1'b1;
            out_d.last         = 1'b1;
            out_d.next_interval = armed_q;
            if (count_q == CntW'(CHANNELS)) begin
              out_d.status  = ST_FULL;
              out_d.channel = '0;
            end else begin
              add_wr  = 1'b1;
              count_d = count_q + CntW'(1);
              if (count_q == '0) begin
                armed_d             = in_item_i.period;
                out_d.next_interval = in_item_i.period;
              end
              out_d.status  = ST_ADDED;
              out_d.channel = ChanW'(count_q);
            end
          end else begin
            ctrl.expire = 1'b1;
            step_d      = '0;
            state_d     = S_MIN;
          end
        end
      end
      S_MIN: begin
        ctrl.min_run = 1'b1;
        if (step_q == CntW'(CHANNELS)) begin
          armed_d = (count_q == '0) ? '0 : min_chain[CHANNELS];
          pwalk_d = '0;
          state_d = S_EMIT;
        end else begin
          step_d = step_q + CntW'(1);
        end
      end
      S_EMIT: begin
        if (can_emit) begin
          if (found_chain[CHANNELS]) begin
            ctrl.take           = 1'b1;
            out_load            = 1'b1;
            out_d.status        = ST_FIRED;
            out_d.channel       = ChanW'(idx_chain[CHANNELS]);
            out_d.next_interval = armed_q;
            out_d.last          = 1'b0;
          end else if (pwalk_q == PrioW'(PrioTop)) begin
            state_d = S_REPORT;
          end else begin
            pwalk_d = pwalk_q + PrioW'(1);
          end
        end
      end
      S_REPORT: begin
        if (can_emit) begin
          out_load            = 1'b1;
          out_d.status        = ST_REPORT;
          out_d.channel       = '0;
          out_d.next_interval = armed_q;
          out_d.last          = 1'b1;
          state_d             = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      step_q      <= '0;
      armed_q     <= '0;
      pwalk_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      step_q  <= step_d;
      armed_q <= armed_d;
      pwalk_q <= pwalk_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CHANNELS))
    else $error("Channel count exceeds the table size.");

  a_empty_unarmed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (armed_q == '0))
    else $error("Interval armed with no channels in the table.");

  a_report_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REPORT && can_emit) |=> (state_q == S_IDLE && out_valid_q
      && out_q.status == ST_REPORT && out_q.last))
    else $error("Interval report did not close the expiry item.");

  a_fired_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == ST_FIRED) |-> !out_q.last)
    else $error("Fired channel result marked as last.");

endmodule
